FILE: hw/rtl/thw_pkg.sv
// tar header walker package: widths, header field positions, result kinds and the
// queued event type shared by the front, queue and back modules
`timescale 1ns / 1ps

package thw_pkg;

   localparam int OFFSET_BITS = 40;
   localparam int POS_OUT_BITS = 40;
   localparam int SIZE_BITS = 36;
   localparam int SKIP_BITS = 37;
   localparam int KIND_BITS = 3;

   localparam int BLOCK_LAST = 511;
   localparam int MAGIC_POS = 257;
   localparam int MAGIC_LEN = 5;
   localparam int SIZE_POS = 124;
   localparam int SIZE_LEN = 12;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   localparam logic [KIND_BITS-1:0] KIND_FILE = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_END_FILES = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_END_EMPTY = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_NOT_USTAR = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_OVERFLOW = 3'd4;

   typedef struct packed {
      logic                    has_entry;
      logic                    has_status;
      logic [KIND_BITS-1:0]    status_kind;
      logic [POS_OUT_BITS-1:0] hdr_pos;
      logic [POS_OUT_BITS-1:0] body_pos;
      logic [SIZE_BITS-1:0]    file_size;
   } thw_event_type;

   function automatic logic [7:0] magic_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0: ch = 8'h75;
         3'd1: ch = 8'h73;
         3'd2: ch = 8'h74;
         3'd3: ch = 8'h61;
         3'd4: ch = 8'h72;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

FILE: hw/rtl/thw_front.sv
// tar header walker front: takes archive bytes, tracks block position,
// magic, size field and data skip, and pushes result events to the queue
// depends on thw_pkg
`timescale 1ns / 1ps

module thw_front import thw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [7:0]    req_data_byte,
   input  logic          req_last_byte,
   input  logic          q_full,
   output logic          q_push,
   output thw_event_type q_event
);

   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_SKIP = 2'd1;
   localparam logic [1:0] PH_DONE = 2'd2;

   logic [8:0]             pos_ff, pos_in;
   logic [1:0]             phase_ff, phase_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [SIZE_BITS-1:0]   acc_ff, acc_in;
   logic [SKIP_BITS-1:0]   skip_ff, skip_in;
   logic                   nonzero_ff, nonzero_in;
   logic [MAGIC_LEN-1:0]   magic_ff, magic_in;
   logic                   first_ff, first_in;
   logic                   any_ff, any_in;

   logic                   done, take, in_hdr, blk_end, nonzero_now;
   logic                   is_magic, is_digit, blk_st, ovf, entry, st_valid;
   logic                   first_after, any_after;
   logic [2:0]             magic_idx;
   logic [KIND_BITS-1:0]   blk_kind, st_kind;
   logic [SKIP_BITS-1:0]   round_sum, round_size, skip_dec;

   assign done = (phase_ff == PH_DONE);
   assign req_ready = done || !q_full;
   assign take = req_valid && req_ready;

   always_comb begin
      in_hdr = (phase_ff == PH_HEADER);
      blk_end = in_hdr && (pos_ff == 9'(BLOCK_LAST));
      nonzero_now = nonzero_ff || (req_data_byte != 8'd0);
      is_magic = (pos_ff >= 9'(MAGIC_POS)) && (pos_ff < 9'(MAGIC_POS + MAGIC_LEN));
      magic_idx = 3'(pos_ff - 9'(MAGIC_POS));
      is_digit = (pos_ff >= 9'(SIZE_POS)) && (pos_ff < 9'(SIZE_POS + SIZE_LEN))
                 && (req_data_byte inside {[8'h30:8'h37]});
      ovf = (offset_ff == '1);

      blk_st = 1'b0;
      blk_kind = KIND_NOT_USTAR;
      if (blk_end) begin
         if (first_ff && (magic_ff != '1)) begin
            blk_st = 1'b1;
            blk_kind = KIND_NOT_USTAR;
         end else if (!nonzero_now) begin
            blk_st = 1'b1;
            blk_kind = any_ff ? KIND_END_FILES : KIND_END_EMPTY;
         end
      end

      first_after = first_ff && !blk_end;
      entry = 1'b0;
      st_valid = 1'b0;
      st_kind = blk_kind;
      if (blk_st) begin
         st_valid = 1'b1;
      end else if (ovf) begin
         st_valid = 1'b1;
         st_kind = KIND_OVERFLOW;
      end else begin
         entry = blk_end;
         if (req_last_byte) begin
            st_valid = 1'b1;
            if (first_after) begin
               st_kind = KIND_NOT_USTAR;
            end else begin
               st_kind = (any_ff || entry) ? KIND_END_FILES : KIND_END_EMPTY;
            end
         end
      end
      any_after = any_ff || entry;

      round_sum = {1'b0, acc_ff} + SKIP_BITS'(BLOCK_LAST);
      round_size = {round_sum[SKIP_BITS-1:9], 9'd0};
      skip_dec = skip_ff - SKIP_BITS'(1);

      q_event.has_entry = entry;
      q_event.has_status = st_valid;
      q_event.status_kind = st_kind;
      q_event.hdr_pos = POS_OUT_BITS'(offset_ff - OFFSET_BITS'(BLOCK_LAST));
      q_event.body_pos = POS_OUT_BITS'(offset_ff + OFFSET_BITS'(1));
      q_event.file_size = acc_ff;
      q_push = take && !done && (entry || st_valid);

      pos_in = pos_ff;
      phase_in = phase_ff;
      offset_in = offset_ff;
      acc_in = acc_ff;
      skip_in = skip_ff;
      nonzero_in = nonzero_ff;
      magic_in = magic_ff;
      first_in = first_ff;
      any_in = any_ff;

      if (take && !done) begin
         if (in_hdr) begin
            nonzero_in = nonzero_now;
            if (first_ff && is_magic && (req_data_byte == magic_char(magic_idx))) begin
               magic_in[magic_idx] = 1'b1;
            end
            if (is_digit) begin
               acc_in = {acc_ff[SIZE_BITS-4:0], req_data_byte[2:0]};
            end
            if (blk_end) begin
               first_in = 1'b0;
               nonzero_in = 1'b0;
               acc_in = '0;
            end
         end else begin
            skip_in = skip_dec;
            if (skip_dec == '0) begin
               phase_in = PH_HEADER;
            end
         end
         if (entry) begin
            any_in = any_after;
            skip_in = round_size;
            if (round_size != '0) begin
               phase_in = PH_SKIP;
            end
         end
         if (st_valid) begin
            phase_in = PH_DONE;
         end
         pos_in = pos_ff + 9'd1;
         offset_in = offset_ff + OFFSET_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         phase_ff <= PH_HEADER;
         offset_ff <= '0;
         acc_ff <= '0;
         skip_ff <= '0;
         nonzero_ff <= 1'b0;
         magic_ff <= '0;
         first_ff <= 1'b1;
         any_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         phase_ff <= phase_in;
         offset_ff <= offset_in;
         acc_ff <= acc_in;
         skip_ff <= skip_in;
         nonzero_ff <= nonzero_in;
         magic_ff <= magic_in;
         first_ff <= first_in;
         any_ff <= any_in;
      end
   end

   // once the end status is out, the walk stays finished
   a_done_sticks: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DONE |=> phase_ff == PH_DONE)
      else $error("walk left the done phase");

   // data skip always starts at a block boundary, so it returns to a header at one
   a_skip_aligned: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SKIP && $past(phase_ff) == PH_HEADER) |-> pos_ff == 9'd0)
      else $error("data skip started off a block boundary");

endmodule

FILE: hw/rtl/thw_queue.sv
// tar header walker event queue: four entries between front and back
// so that each side can stall on its own
// depends on thw_pkg
`timescale 1ns / 1ps

module thw_queue import thw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  thw_event_type push_event,
   input  logic          pop,
   output logic          full,
   output logic          empty,
   output thw_event_type head
);

   thw_event_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]     count_ff, count_in;

   assign full = (count_ff == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + QUEUE_PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QUEUE_PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (QUEUE_PTR_BITS + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QUEUE_PTR_BITS + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_event;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into a full queue");

   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("pop from an empty queue");

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      full || (wr_ptr_ff == QUEUE_PTR_BITS'(rd_ptr_ff + count_ff[QUEUE_PTR_BITS-1:0])))
      else $error("queue pointers and count disagree");

endmodule

FILE: hw/rtl/thw_back.sv
// tar header walker back: turns queued events into result items, entry
// first and end status second, through a registered output stage
// depends on thw_pkg
`timescale 1ns / 1ps

module thw_back import thw_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  thw_event_type           q_head,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [KIND_BITS-1:0]    rsp_record_kind,
   output logic [POS_OUT_BITS-1:0] rsp_header_offset,
   output logic [POS_OUT_BITS-1:0] rsp_data_offset,
   output logic [SIZE_BITS-1:0]    rsp_file_size,
   output logic                    rsp_run_end
);

   logic                    valid_ff, valid_in;
   logic                    sent_ff, sent_in;
   logic [KIND_BITS-1:0]    kind_ff, kind_in;
   logic [POS_OUT_BITS-1:0] hdr_ff, hdr_in;
   logic [POS_OUT_BITS-1:0] data_ff, data_in;
   logic [SIZE_BITS-1:0]    size_ff, size_in;
   logic                    end_ff, end_in;
   logic                    load;

   assign load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      sent_in = sent_ff;
      kind_in = kind_ff;
      hdr_in = hdr_ff;
      data_in = data_ff;
      size_in = size_ff;
      end_in = end_ff;
      q_pop = 1'b0;
      if (load) begin
         valid_in = !q_empty;
         if (!q_empty) begin
            if (q_head.has_entry && !sent_ff) begin
               kind_in = KIND_FILE;
               hdr_in = q_head.hdr_pos;
               data_in = q_head.body_pos;
               size_in = q_head.file_size;
               end_in = !q_head.has_status;
               sent_in = q_head.has_status;
               q_pop = !q_head.has_status;
            end else begin
               kind_in = q_head.status_kind;
               hdr_in = '0;
               data_in = '0;
               size_in = '0;
               end_in = 1'b1;
               sent_in = 1'b0;
               q_pop = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sent_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sent_ff <= sent_in;
      end
      kind_ff <= kind_in;
      hdr_ff <= hdr_in;
      data_ff <= data_in;
      size_ff <= size_in;
      end_ff <= end_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_record_kind = kind_ff;
   assign rsp_header_offset = hdr_ff;
   assign rsp_data_offset = data_ff;
   assign rsp_file_size = size_ff;
   assign rsp_run_end = end_ff;

   // an entry waiting on its end status is on the output and not final
   a_split_entry: assert property (@(posedge clock) disable iff (reset)
      sent_ff |-> (valid_ff && kind_ff == KIND_FILE && !end_ff))
      else $error("split event lost its entry");

endmodule

FILE: hw/rtl/tar_header_walker.sv
// Accepts one archive byte per clock and reports tar entries and the end
// status. Each byte passes through the front walker (block counter,
// octal shift-add and data-skip down counter); results wait in a
// four-event queue and leave through a registered output stage, one per
// cycle while taken, so a byte that both closes a header and ends the
// archive gives its two results one after the other. Input only stalls
// when the queue is full because results are not being taken. After the
// end status all further bytes are taken and dropped until reset.
// depends on thw_pkg, thw_front, thw_queue, thw_back
`timescale 1ns / 1ps

module tar_header_walker import thw_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_last_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [KIND_BITS-1:0]    rsp_record_kind,
   output logic [POS_OUT_BITS-1:0] rsp_header_offset,
   output logic [POS_OUT_BITS-1:0] rsp_data_offset,
   output logic [SIZE_BITS-1:0]    rsp_file_size,
   output logic                    rsp_run_end
);

   logic          q_full, q_empty, q_push, q_pop;
   thw_event_type q_event, q_head;

   thw_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_event       (q_event)
   );

   thw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_event (q_event),
      .pop        (q_pop),
      .full       (q_full),
      .empty      (q_empty),
      .head       (q_head)
   );

   thw_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_record_kind   (rsp_record_kind),
      .rsp_header_offset (rsp_header_offset),
      .rsp_data_offset   (rsp_data_offset),
      .rsp_file_size     (rsp_file_size),
      .rsp_run_end       (rsp_run_end)
   );

endmodule

FILE: tb/tb.sv
// self-checking testbench for tar_header_walker: streams ustar archives byte by byte
// and checks every entry and end status against a cycle-free predictor of the walk
// depends on thw_pkg and tar_header_walker
`timescale 1ns / 1ps

module tb import thw_pkg::*; ();

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int HOLD_CYCLES = 4000;
   localparam int RANDOM_HEADERS = 40;
   localparam int BURST_HEADERS = 14;
   localparam int DRAIN_CYCLES = 40;
   localparam int BLOCK_BYTES = BLOCK_LAST + 1;
   localparam logic [8*MAGIC_LEN-1:0] USTAR_TEXT = "ustar";

   localparam logic [1:0] AT_HEADER = 2'd0;
   localparam logic [1:0] IN_DATA = 2'd1;
   localparam logic [1:0] WALK_DONE = 2'd2;

   typedef struct packed {
      logic [KIND_BITS-1:0]    kind;
      logic [POS_OUT_BITS-1:0] hdr_off;
      logic [POS_OUT_BITS-1:0] data_off;
      logic [SIZE_BITS-1:0]    file_size;
      logic                    ends_byte;
   } walk_result_type;

   typedef struct {
      string  size_text;
      longint size_listed;
      int     fill;
      int     mark_pos;
   } header_case_type;

   // fill < 0 means random background, mark_pos >= 0 plants one nonzero byte
   header_case_type header_cases [12] = '{
      '{"00000000000", 0, -1, -1},
      '{"00000000001", 1, -1, -1},
      '{"      777 ", 511, 255, -1},
      '{"00000001000", 512, 0, -1},
      '{"1001", 513, -1, -1},
      '{"1x2 9 8\t3", 83, -1, -1},
      '{"", 0, 0, 511},
      '{"", 0, 0, 0},
      '{"/0_7:8", 7, 0, -1},
      '{"            ", 0, 255, -1},
      '{"7777", 4095, -1, -1},
      '{"00 00 00 2 ", 2, -1, -1}
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [7:0]              req_data_byte = 8'h00;
   logic                    req_last_byte = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [KIND_BITS-1:0]    rsp_record_kind;
   logic [POS_OUT_BITS-1:0] rsp_header_offset;
   logic [POS_OUT_BITS-1:0] rsp_data_offset;
   logic [SIZE_BITS-1:0]    rsp_file_size;
   logic                    rsp_run_end;

   // walk state of the predictor
   logic [8:0]             blk_pos;
   logic [1:0]             phase;
   logic [OFFSET_BITS-1:0] next_offset;
   logic [SIZE_BITS-1:0]   size_acc;
   logic [SKIP_BITS-1:0]   skip_left;
   logic                   hdr_nonzero;
   logic [MAGIC_LEN-1:0]   magic_seen;
   logic                   in_first;
   logic                   had_entry;

   walk_result_type      results_due [$];
   logic [SIZE_BITS-1:0] listed_sizes [$];
   logic [7:0]           block_buf [0:BLOCK_LAST];

   int fail_count = 0;
   int cycle_count = 0;
   bit hold_wanted = 1'b0;
   bit tx_calm = 1'b0;

   tar_header_walker dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_record_kind   (rsp_record_kind),
      .rsp_header_offset (rsp_header_offset),
      .rsp_data_offset   (rsp_data_offset),
      .rsp_file_size     (rsp_file_size),
      .rsp_run_end       (rsp_run_end)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function void reset_walk();
      blk_pos = '0;
      phase = AT_HEADER;
      next_offset = '0;
      size_acc = '0;
      skip_left = '0;
      hdr_nonzero = 1'b0;
      magic_seen = '0;
      in_first = 1'b1;
      had_entry = 1'b0;
   endfunction

   function void add_result(input logic [KIND_BITS-1:0] kind,
                            input logic [POS_OUT_BITS-1:0] hdr_off,
                            input logic [POS_OUT_BITS-1:0] data_off,
                            input logic [SIZE_BITS-1:0] file_size,
                            input logic ends_byte);
      walk_result_type r;
      r.kind = kind;
      r.hdr_off = hdr_off;
      r.data_off = data_off;
      r.file_size = file_size;
      r.ends_byte = ends_byte;
      results_due.insert(results_due.size(), r);
   endfunction

   function void walk_byte(input logic [7:0] b, input logic last);
      logic [KIND_BITS-1:0]   status;
      bit                     have_status;
      bit                     entry;
      logic [OFFSET_BITS-1:0] hdr_at;
      logic [SIZE_BITS-1:0]   esize;
      logic [SIZE_BITS-1:0]   shown_size;
      int                     idx;
      have_status = 1'b0;
      entry = 1'b0;
      status = KIND_FILE;
      hdr_at = '0;
      esize = '0;
      idx = int'(blk_pos) - MAGIC_POS;
      if (phase == WALK_DONE) return;
      if (phase == AT_HEADER) begin
         if (b != 8'h00) hdr_nonzero = 1'b1;
         if (in_first && idx >= 0 && idx < MAGIC_LEN &&
             b == USTAR_TEXT[8*(MAGIC_LEN-1-idx) +: 8]) magic_seen[idx] = 1'b1;
         if (blk_pos >= SIZE_POS && blk_pos < SIZE_POS + SIZE_LEN && b >= "0" && b <= "7")
            size_acc = {size_acc[SIZE_BITS-4:0], b[2:0]};
         if (blk_pos == BLOCK_LAST) begin
            if (in_first && magic_seen != '1) begin
               have_status = 1'b1;
               status = KIND_NOT_USTAR;
            end else if (!hdr_nonzero) begin
               have_status = 1'b1;
               status = had_entry ? KIND_END_FILES : KIND_END_EMPTY;
            end else begin
               entry = 1'b1;
               hdr_at = next_offset - OFFSET_BITS'(BLOCK_LAST);
               esize = size_acc;
            end
            in_first = 1'b0;
            hdr_nonzero = 1'b0;
            size_acc = '0;
         end
      end else begin
         skip_left = skip_left - SKIP_BITS'(1);
         if (skip_left == '0) phase = AT_HEADER;
      end
      blk_pos = blk_pos + 9'd1;

      if (have_status) begin
         add_result(status, '0, '0, '0, 1'b1);
         phase = WALK_DONE;
      end else if (next_offset == '1) begin
         add_result(KIND_OVERFLOW, '0, '0, '0, 1'b1);
         phase = WALK_DONE;
      end else begin
         if (entry) begin
            shown_size = esize;
            if (listed_sizes.size() != 0) shown_size = listed_sizes.pop_front();
            add_result(KIND_FILE, hdr_at, next_offset + OFFSET_BITS'(1), shown_size, !last);
            had_entry = 1'b1;
            skip_left = ({1'b0, esize} + SKIP_BITS'(BLOCK_LAST)) & ~SKIP_BITS'(BLOCK_LAST);
            if (skip_left != '0) phase = IN_DATA;
         end
         if (last) begin
            add_result(in_first ? KIND_NOT_USTAR : (had_entry ? KIND_END_FILES : KIND_END_EMPTY),
                       '0, '0, '0, 1'b1);
            phase = WALK_DONE;
         end
      end
      next_offset = next_offset + OFFSET_BITS'(1);
   endfunction

   function void compare_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d got %0d", $time, what, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      walk_result_type want;
      if (!reset) begin
         if (req_valid && req_ready) walk_byte(req_data_byte, req_last_byte);
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               $display("%0t: result with nothing expected, expected none got kind %0d",
                        $time, rsp_record_kind);
               fail_count++;
            end else begin
               want = results_due.pop_front();
               compare_field("record_kind", want.kind, rsp_record_kind);
               compare_field("header_offset", want.hdr_off, rsp_header_offset);
               compare_field("data_offset", want.data_off, rsp_data_offset);
               compare_field("file_size", want.file_size, rsp_file_size);
               compare_field("run_end", want.ends_byte, rsp_run_end);
            end
         end
      end
   end

   function int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   initial begin : result_taker
      int gap;
      int stretch;
      bit calm;
      bit hold_done;
      stretch = 0;
      calm = 1'b0;
      hold_done = 1'b0;
      forever begin
         if (stretch == 0) begin
            calm = ($urandom_range(0, 3) == 0);
            stretch = $urandom_range(50, 400);
         end
         stretch--;
         if (hold_wanted && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = calm ? 0 : idle_len();
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // request stays up with the same byte until taken
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = tx_calm ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_block(input int count, input bit last_at_end, input bit calm);
      tx_calm = calm || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < count; i++) send_byte(block_buf[i], last_at_end && i == count - 1);
   endtask

   task automatic send_filler(input int count, input bit last_at_end);
      int pick;
      logic [7:0] b;
      tx_calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 3);
         b = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hff : 8'($urandom);
         send_byte(b, last_at_end && i == count - 1);
      end
   endtask

   function int padded(input longint v);
      return int'((v + BLOCK_LAST) / BLOCK_BYTES * BLOCK_BYTES);
   endfunction

   function void fill_block(input int fill, input bit with_magic);
      for (int i = 0; i < BLOCK_BYTES; i++)
         block_buf[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
      if (with_magic)
         for (int j = 0; j < MAGIC_LEN; j++)
            block_buf[MAGIC_POS + j] = USTAR_TEXT[8*(MAGIC_LEN-1-j) +: 8];
   endfunction

   function void write_size_text(input string t);
      for (int i = 0; i < SIZE_LEN; i++)
         block_buf[SIZE_POS + i] = (i < t.len()) ? t[i] : 8'h00;
   endfunction

   // style 0 zero padded, 1 space padded, 2 digits scattered among junk bytes
   function void write_size_value(input int v, input int style);
      int nd;
      int p;
      int slot;
      logic [7:0] ch;
      logic [2:0] od [SIZE_LEN];
      nd = 1;
      while (nd < SIZE_LEN && (v >> (3 * nd)) != 0) nd++;
      for (int k = 0; k < nd; k++) od[k] = 3'(v >> (3 * (nd - 1 - k)));
      for (int i = 0; i < SIZE_LEN; i++) begin
         case (style)
            0: ch = (i == SIZE_LEN - 1) ? 8'h00 : "0";
            1: ch = (i == SIZE_LEN - 1 && $urandom_range(0, 1) == 0) ? 8'h00 : " ";
            default: begin
               ch = 8'($urandom);
               if (ch >= "0" && ch <= "7") ch = ch + 8'd8;
            end
         endcase
         block_buf[SIZE_POS + i] = ch;
      end
      if (style < 2) begin
         for (int k = 0; k < nd; k++)
            block_buf[SIZE_POS + SIZE_LEN - 1 - nd + k] = "0" + od[k];
      end else begin
         p = 0;
         for (int k = 0; k < nd; k++) begin
            slot = $urandom_range(p, SIZE_LEN - nd + k);
            block_buf[SIZE_POS + slot] = "0" + od[k];
            p = slot + 1;
         end
      end
   endfunction

   function void random_header(input int v);
      int style;
      style = $urandom_range(0, 3);
      fill_block(style == 1 ? 0 : (style == 2 ? 255 : -1), $urandom_range(0, 1));
      if (style == 1) block_buf[$urandom_range(0, BLOCK_LAST)] = 8'($urandom_range(1, 255));
      write_size_value(v, $urandom_range(0, 2));
   endfunction

   function int pick_size();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return 0;
      if (r < 8) return $urandom_range(1, 600);
      return $urandom_range(601, 2000);
   endfunction

   initial begin : stimulus
      int v;
      int count;
      int burst_at;
      reset_walk();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (header_cases[i]) begin
         fill_block(header_cases[i].fill, i == 0);
         if (header_cases[i].mark_pos >= 0)
            block_buf[header_cases[i].mark_pos] = 8'($urandom_range(1, 255));
         write_size_text(header_cases[i].size_text);
         listed_sizes.insert(listed_sizes.size(), SIZE_BITS'(header_cases[i].size_listed));
         send_block(BLOCK_BYTES, 1'b0, 1'b0);
         send_filler(padded(header_cases[i].size_listed), 1'b0);
      end

      burst_at = $urandom_range(3, 10);
      for (int h = 0; h < RANDOM_HEADERS; h++) begin
         if (h == burst_at) begin
            hold_wanted = 1'b1;
            repeat (BURST_HEADERS) begin
               random_header(0);
               send_block(BLOCK_BYTES, 1'b0, 1'b1);
            end
         end
         v = pick_size();
         random_header(v);
         send_block(BLOCK_BYTES, 1'b0, 1'b0);
         send_filler(padded(v), 1'b0);
      end

      case ($urandom_range(0, 3))
         0: begin
            fill_block(0, 1'b0);
            send_block(BLOCK_BYTES, 1'b0, 1'b0);
         end
         1: begin
            fill_block(-1, 1'b0);
            write_size_text("777777777777");
            send_block(BLOCK_BYTES, 1'b0, 1'b0);
            send_filler($urandom_range(1, 40), 1'b1);
         end
         2: begin
            random_header($urandom_range(0, 600));
            send_block(BLOCK_BYTES, 1'b1, 1'b0);
         end
         default: begin
            fill_block(-1, 1'b0);
            send_block($urandom_range(1, BLOCK_LAST), 1'b1, 1'b0);
         end
      endcase

      // walk has ended, these are taken and dropped
      count = $urandom_range(5, 20);
      for (int i = 0; i < count; i++) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
      req_valid <= 1'b0;
      @(posedge clock);

      while (results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (results_due.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, results_due.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
